/* sv/qir_pkg.sv */
// Shared constants and types for the quintic impedance ramp.
// Used by the top level, the blend-factor unit, the port checker and the testbench.
`timescale 1ns / 1ps

package qir_pkg;

   // Field widths
   localparam int JOINT_W = 6;
   localparam int VAL_W   = 16;
   localparam int Q16_W   = 17;
   localparam int TAU_W   = 17;

   // Joint count default and its legal ceiling
   localparam int NUM_JOINTS_DEF = 8;
   localparam int MAX_JOINTS     = 64;

   // Fixed-point constants
   localparam logic [Q16_W-1:0] ONE_Q16   = 17'h10000;
   localparam logic [15:0]      HALF_LSB  = 16'h8000;
   localparam logic [TAU_W-1:0] TAU_RESET = 17'd13;

   // Number of r = (r*t + half) >> 16 passes in the blend polynomial
   localparam int POLY_MUL_STEPS = 3;

   // Request function codes
   typedef enum logic [1:0] {
      FUNC_LOAD_START = 2'd0,
      FUNC_LOAD_HOME  = 2'd1,
      FUNC_RESTART    = 2'd2,
      FUNC_TICK       = 2'd3
   } func_type;

   // Status returned by the blend-factor unit
   typedef struct packed {
      logic             done;
      logic [Q16_W-1:0] alpha;
   } poly_rsp_type;

endpackage

/* sv/quintic_impedance_ramp.sv */
// Per-joint stiffness/damping ramp with quintic smoothstep blending.
// Depends on qir_pkg and qir_poly; start and home values live in two memories.
`timescale 1ns / 1ps

// Load items (func 0 start, 1 home) write one joint's stiffness and damping
// into the start or home memory; joints at or above NUM_JOINTS are dropped.
// A restart item (func 2) zeroes normalized time and arms the ramp. A tick
// (func 3) with the ramp idle returns nothing. An armed tick runs the blend
// polynomial in the iterative unit and then walks the joints in order through
// memory read, difference, multiply, and round and add; the round-and-add step
// waits while the result register is stalled. No new request is taken until
// the last result of the tick is registered. Each tick returns one result per
// joint, last set on the final one, finished set on every result of the tick
// that ran at t = 1.0, after which the ramp disarms. tau_step is written
// through the csr port while idle. Memories start as all zero through
// per-joint valid bits, with no clear pass.
module quintic_impedance_ramp #(
   parameter int NUM_JOINTS = qir_pkg::NUM_JOINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_func,
   input  logic [qir_pkg::JOINT_W-1:0]   req_joint,
   input  logic [qir_pkg::VAL_W-1:0]     req_stiffness,
   input  logic [qir_pkg::VAL_W-1:0]     req_damping,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [qir_pkg::JOINT_W-1:0]   rsp_joint_out,
   output logic [qir_pkg::VAL_W-1:0]     rsp_stiffness_ref,
   output logic [qir_pkg::VAL_W-1:0]     rsp_damping_ref,
   output logic [qir_pkg::Q16_W-1:0]     rsp_blend,
   output logic                          rsp_last,
   output logic                          rsp_finished,
   // Configuration write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [qir_pkg::TAU_W-1:0]     csr_tau_step
);

   localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
   localparam int VW    = qir_pkg::VAL_W;
   localparam int QW    = qir_pkg::Q16_W;
   localparam int PRD_W = QW + VW;
   localparam int ENT_W = 2 * VW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POLY,
      S_READ,
      S_DIFF,
      S_MUL,
      S_SUM
   } state_type;

   state_type               state_ff;
   logic [IDX_W-1:0]        jnt_ff;
   logic [qir_pkg::TAU_W-1:0] tau_ff;
   logic [QW-1:0]           norm_time_ff;
   logic                    running_ff;
   logic                    fin_ff;
   logic [QW-1:0]           alpha_ff;

   // Joint tables: {stiffness, damping} per entry
   logic [ENT_W-1:0]        start_mem [NUM_JOINTS];
   logic [ENT_W-1:0]        home_mem  [NUM_JOINTS];
   logic [NUM_JOINTS-1:0]   start_vld_ff;
   logic [NUM_JOINTS-1:0]   home_vld_ff;
   logic [ENT_W-1:0]        start_rd_ff;
   logic [ENT_W-1:0]        home_rd_ff;
   logic                    start_ok_ff;
   logic                    home_ok_ff;

   // Per-joint datapath registers
   logic [VW-1:0]           s_stf_ff, s_dmp_ff;
   logic [VW-1:0]           mag_stf_ff, mag_dmp_ff;
   logic                    up_stf_ff, up_dmp_ff;
   logic [PRD_W-1:0]        prod_stf_ff, prod_dmp_ff;

   // Output register
   logic                    rsp_valid_ff;
   logic [qir_pkg::JOINT_W-1:0] rsp_joint_ff;
   logic [VW-1:0]           rsp_stf_ff, rsp_dmp_ff;
   logic [QW-1:0]           rsp_blend_ff;
   logic                    rsp_last_ff, rsp_fin_ff;

   logic                    req_fire;
   qir_pkg::func_type       func;
   logic                    joint_ok;
   logic [IDX_W-1:0]        wr_idx;
   logic [QW-1:0]           t_cur;
   logic [QW:0]             time_sum;
   logic [QW-1:0]           norm_time_in;
   logic                    poly_start;
   qir_pkg::poly_rsp_type   poly_rsp;
   logic [VW-1:0]           s_stf, s_dmp, h_stf, h_dmp;
   logic [PRD_W-1:0]        rnd_stf, rnd_dmp;
   logic [VW-1:0]           stf_in, dmp_in;
   logic                    out_free;
   logic                    last_jnt;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign func      = qir_pkg::func_type'(req_func);
   assign joint_ok  = ({1'b0, req_joint} < (qir_pkg::JOINT_W + 1)'(NUM_JOINTS));
   assign wr_idx    = req_joint[IDX_W-1:0];
   assign last_jnt  = (jnt_ff == IDX_W'(NUM_JOINTS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Clamp time, then advance by tau with saturation at 1.0
   always_comb begin
      t_cur        = (norm_time_ff > qir_pkg::ONE_Q16) ? qir_pkg::ONE_Q16 : norm_time_ff;
      time_sum     = {1'b0, t_cur} + (QW + 1)'(tau_ff);
      norm_time_in = (time_sum > (QW + 1)'(qir_pkg::ONE_Q16)) ? qir_pkg::ONE_Q16
                                                            : time_sum[QW-1:0];
   end

   assign poly_start = req_fire && (func == qir_pkg::FUNC_TICK) && running_ff;

   qir_poly u_poly (
      .clock (clock),
      .reset (reset),
      .start (poly_start),
      .t     (t_cur),
      .rsp   (poly_rsp)
   );

   // Write on load transfers, read the current joint every cycle
   always_ff @(posedge clock) begin
      if (req_fire && joint_ok && (func == qir_pkg::FUNC_LOAD_START)) begin
         start_mem[wr_idx] <= {req_stiffness, req_damping};
      end
      if (req_fire && joint_ok && (func == qir_pkg::FUNC_LOAD_HOME)) begin
         home_mem[wr_idx] <= {req_stiffness, req_damping};
      end
      start_rd_ff <= start_mem[jnt_ff];
      home_rd_ff  <= home_mem[jnt_ff];
   end

   // Valid bits stand in for a cleared table after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         start_vld_ff <= '0;
         home_vld_ff  <= '0;
      end else begin
         if (req_fire && joint_ok && (func == qir_pkg::FUNC_LOAD_START)) begin
            start_vld_ff[wr_idx] <= 1'b1;
         end
         if (req_fire && joint_ok && (func == qir_pkg::FUNC_LOAD_HOME)) begin
            home_vld_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ok_ff <= start_vld_ff[jnt_ff];
      home_ok_ff  <= home_vld_ff[jnt_ff];
   end

   // Unwritten entries read as zero
   always_comb begin
      s_stf = start_ok_ff ? start_rd_ff[ENT_W-1:VW] : '0;
      s_dmp = start_ok_ff ? start_rd_ff[VW-1:0]     : '0;
      h_stf = home_ok_ff  ? home_rd_ff[ENT_W-1:VW]  : '0;
      h_dmp = home_ok_ff  ? home_rd_ff[VW-1:0]      : '0;
   end

   // Round the scaled magnitude half up and move from start toward home
   always_comb begin
      rnd_stf = prod_stf_ff + PRD_W'(qir_pkg::HALF_LSB);
      rnd_dmp = prod_dmp_ff + PRD_W'(qir_pkg::HALF_LSB);
      stf_in  = up_stf_ff ? (s_stf_ff + rnd_stf[16 +: VW]) : (s_stf_ff - rnd_stf[16 +: VW]);
      dmp_in  = up_dmp_ff ? (s_dmp_ff + rnd_dmp[16 +: VW]) : (s_dmp_ff - rnd_dmp[16 +: VW]);
   end

   // Per-joint datapath stages
   always_ff @(posedge clock) begin
      if (state_ff == S_DIFF) begin
         s_stf_ff   <= s_stf;
         s_dmp_ff   <= s_dmp;
         up_stf_ff  <= (h_stf >= s_stf);
         up_dmp_ff  <= (h_dmp >= s_dmp);
         mag_stf_ff <= (h_stf >= s_stf) ? (h_stf - s_stf) : (s_stf - h_stf);
         mag_dmp_ff <= (h_dmp >= s_dmp) ? (h_dmp - s_dmp) : (s_dmp - h_dmp);
      end
      if (state_ff == S_MUL) begin
         prod_stf_ff <= PRD_W'(alpha_ff) * PRD_W'(mag_stf_ff);
         prod_dmp_ff <= PRD_W'(alpha_ff) * PRD_W'(mag_dmp_ff);
      end
   end

   // Sequencer: ramp state, joint walk and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         jnt_ff       <= '0;
         tau_ff       <= qir_pkg::TAU_RESET;
         norm_time_ff <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop a transferred result unless S_SUM reloads the register
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_SUM)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            tau_ff <= csr_tau_step;
         end
         case (state_ff)
            S_IDLE: begin
               jnt_ff <= '0;
               if (req_fire) begin
                  case (func)
                     qir_pkg::FUNC_RESTART: begin
                        norm_time_ff <= '0;
                        running_ff   <= 1'b1;
                     end
                     qir_pkg::FUNC_TICK: begin
                        if (running_ff) begin
                           fin_ff <= t_cur[QW-1];
                           if (t_cur[QW-1]) begin
                              running_ff <= 1'b0;
                           end else begin
                              norm_time_ff <= norm_time_in;
                           end
                           state_ff <= S_POLY;
                        end
                     end
                     default: begin
                        // loads go to the memories only
                     end
                  endcase
               end
            end
            S_POLY: begin
               if (poly_rsp.done) begin
                  alpha_ff <= poly_rsp.alpha;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               state_ff <= S_MUL;
            end
            S_MUL: begin
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_joint_ff <= qir_pkg::JOINT_W'(jnt_ff);
                  rsp_stf_ff   <= stf_in;
                  rsp_dmp_ff   <= dmp_in;
                  rsp_blend_ff <= alpha_ff;
                  rsp_last_ff  <= last_jnt;
                  rsp_fin_ff   <= fin_ff;
                  if (last_jnt) begin
                     jnt_ff   <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     jnt_ff   <= jnt_ff + IDX_W'(1);
                     state_ff <= S_READ;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_joint_out     = rsp_joint_ff;
   assign rsp_stiffness_ref = rsp_stf_ff;
   assign rsp_damping_ref   = rsp_dmp_ff;
   assign rsp_blend         = rsp_blend_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_finished      = rsp_fin_ff;

endmodule

/* sv/qir_poly.sv */
// Iterative unit for the quintic blend factor 6t^5 - 15t^4 + 10t^3 in Q1.16.
// Depends on qir_pkg; one multiplier for t squared, one reused over the Horner-style passes.
`timescale 1ns / 1ps

module qir_poly (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [qir_pkg::Q16_W-1:0]    t,
   output qir_pkg::poly_rsp_type        rsp
);

   localparam int TT_W = 2 * qir_pkg::Q16_W;   // t squared
   localparam int Q_W  = 37;                   // q in Q5.32, up to 10 * 2^32
   localparam int R_W  = 20;                   // r in Q4.16, up to 10 * 2^16
   localparam int P_W  = R_W + qir_pkg::Q16_W; // r * t

   typedef enum logic [1:0] {
      P_IDLE,
      P_SQUARE,
      P_BASE,
      P_MUL
   } poly_state_type;

   poly_state_type           state_ff;
   logic [1:0]               step_ff;
   logic                     done_ff;
   logic [qir_pkg::Q16_W-1:0] t_ff;
   logic [TT_W-1:0]          tt_ff;
   logic [R_W-1:0]           r_ff;

   logic [Q_W-1:0]           q_in;
   logic [Q_W-1:0]           q_round;
   logic [R_W-1:0]           base_in;
   logic [P_W-1:0]           prod;
   logic [P_W-1:0]           prod_round;
   logic [R_W-1:0]           r_in;

   // Form q = 6*t^2 - 15*t*2^16 + 10*2^32 with shifts and adds
   always_comb begin
      q_in = (Q_W'(tt_ff) << 2) + (Q_W'(tt_ff) << 1)
           + (Q_W'(10) << 32)
           - (((Q_W'(t_ff) << 4) - Q_W'(t_ff)) << 16);
      q_round = q_in + Q_W'(qir_pkg::HALF_LSB);
      base_in = q_round[16 +: R_W];
   end

   // One multiply-and-round pass per cycle
   always_comb begin
      prod       = P_W'(r_ff) * P_W'(t_ff);
      prod_round = prod + P_W'(qir_pkg::HALF_LSB);
      r_in       = prod_round[16 +: R_W];
   end

   // Sequence the passes and flag completion
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            P_IDLE: begin
               if (start) begin
                  t_ff     <= t;
                  state_ff <= P_SQUARE;
               end
            end
            P_SQUARE: begin
               tt_ff    <= TT_W'(t_ff) * TT_W'(t_ff);
               state_ff <= P_BASE;
            end
            P_BASE: begin
               r_ff     <= base_in;
               step_ff  <= '0;
               state_ff <= P_MUL;
            end
            P_MUL: begin
               r_ff    <= r_in;
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'(qir_pkg::POLY_MUL_STEPS - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= P_IDLE;
               end
            end
            default: begin
               state_ff <= P_IDLE;
            end
         endcase
      end
   end

   // Clamp to 1.0 on the way out
   assign rsp.done  = done_ff;
   assign rsp.alpha = (r_ff > R_W'(qir_pkg::ONE_Q16)) ? qir_pkg::ONE_Q16
                                                     : r_ff[qir_pkg::Q16_W-1:0];

endmodule

/* sv/qir_checker.sv */
// Port-level checks for the quintic impedance ramp response channel.
// Depends on qir_pkg; attached to the top level by the bind below.
`timescale 1ns / 1ps

module qir_checker #(
   parameter int NUM_JOINTS = qir_pkg::NUM_JOINTS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [qir_pkg::JOINT_W-1:0]   rsp_joint_out,
   input logic [qir_pkg::VAL_W-1:0]     rsp_stiffness_ref,
   input logic [qir_pkg::VAL_W-1:0]     rsp_damping_ref,
   input logic [qir_pkg::Q16_W-1:0]     rsp_blend,
   input logic                          rsp_last,
   input logic                          rsp_finished
);

   // Hold a stalled result unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_joint_out)
         && $stable(rsp_stiffness_ref) && $stable(rsp_damping_ref)
         && $stable(rsp_blend) && $stable(rsp_last) && $stable(rsp_finished))
      else $error("stalled result changed");

   // Keep blend within 0..1.0
   a_blend_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_blend <= qir_pkg::ONE_Q16)
      else $error("blend above one");

   // Flag last exactly on the final joint
   a_last_joint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_joint_out == qir_pkg::JOINT_W'(NUM_JOINTS - 1))))
      else $error("last flag does not match final joint");

   // A finished tick ran at t = 1.0, so the blend is exactly one
   a_finished_blend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_blend == qir_pkg::ONE_Q16)
      else $error("finished result without full blend");

endmodule

bind quintic_impedance_ramp qir_checker #(.NUM_JOINTS(NUM_JOINTS)) u_qir_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_joint_out     (rsp_joint_out),
   .rsp_stiffness_ref (rsp_stiffness_ref),
   .rsp_damping_ref   (rsp_damping_ref),
   .rsp_blend         (rsp_blend),
   .rsp_last          (rsp_last),
   .rsp_finished      (rsp_finished)
);

/* tb/sv/quintic_impedance_ramp_tb.sv */
// Self-checking testbench for quintic_impedance_ramp: directed table, then random phases.
// Depends on qir_pkg and the quintic_impedance_ramp top level, which in turn needs qir_poly.
`timescale 1ns / 1ps

module quintic_impedance_ramp_tb;

   localparam int JOINT_W        = qir_pkg::JOINT_W;
   localparam int VAL_W          = qir_pkg::VAL_W;
   localparam int Q16_W          = qir_pkg::Q16_W;
   localparam int TAU_W          = qir_pkg::TAU_W;
   localparam int POLY_MUL_STEPS = qir_pkg::POLY_MUL_STEPS;
   localparam logic [Q16_W-1:0] ONE_Q16   = qir_pkg::ONE_Q16;
   localparam logic [TAU_W-1:0] TAU_RESET = qir_pkg::TAU_RESET;

   localparam int JOINTS      = qir_pkg::NUM_JOINTS_DEF;
   // an armed tick holds the request side until its last result is registered; leave margin
   localparam int SETTLE      = 64;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_ITEMS = 25;

   // One expected joint setpoint
   typedef struct packed {
      logic [JOINT_W-1:0] joint;
      logic [VAL_W-1:0]   stiff;
      logic [VAL_W-1:0]   damp;
      logic [Q16_W-1:0]   blend;
      logic               last;
      logic               fin;
   } setpoint_type;

   // One row of stimulus; a typed row pins the setpoint of its joint field
   typedef struct packed {
      logic               is_cfg;
      logic [TAU_W-1:0]   tau;
      logic [1:0]         func;
      logic [JOINT_W-1:0] joint;
      logic [VAL_W-1:0]   stiff;
      logic [VAL_W-1:0]   damp;
      logic               typed;
      logic [VAL_W-1:0]   exp_stiff;
      logic [VAL_W-1:0]   exp_damp;
      logic [Q16_W-1:0]   exp_blend;
      logic               exp_fin;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_func;
   logic [JOINT_W-1:0]  req_joint;
   logic [VAL_W-1:0]    req_stiffness;
   logic [VAL_W-1:0]    req_damping;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [JOINT_W-1:0]  rsp_joint_out;
   logic [VAL_W-1:0]    rsp_stiffness_ref;
   logic [VAL_W-1:0]    rsp_damping_ref;
   logic [Q16_W-1:0]    rsp_blend;
   logic                rsp_last;
   logic                rsp_finished;
   logic                csr_valid;
   logic                csr_ready;
   logic [TAU_W-1:0]    csr_tau_step;

   // Predictor state
   logic [VAL_W-1:0]    start_stiff [JOINTS];
   logic [VAL_W-1:0]    start_damp  [JOINTS];
   logic [VAL_W-1:0]    home_stiff  [JOINTS];
   logic [VAL_W-1:0]    home_damp   [JOINTS];
   logic [Q16_W-1:0]    ramp_time;
   logic                ramp_armed;
   logic [TAU_W-1:0]    tau_now;
   setpoint_type        pending_setpoints[$];

   // Run bookkeeping
   logic                calm;
   int                  mismatches;
   int                  items_sent;
   int                  setpoints_seen;
   int                  active_ticks;
   int                  tau_writes;
   int                  stall_left;

   quintic_impedance_ramp #(
      .NUM_JOINTS(JOINTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_joint(req_joint),
      .req_stiffness(req_stiffness),
      .req_damping(req_damping),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_joint_out(rsp_joint_out),
      .rsp_stiffness_ref(rsp_stiffness_ref),
      .rsp_damping_ref(rsp_damping_ref),
      .rsp_blend(rsp_blend),
      .rsp_last(rsp_last),
      .rsp_finished(rsp_finished),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_tau_step(csr_tau_step)
   );

   // Free-running clock, 2 ns period
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // alpha = 6t^5 - 15t^4 + 10t^3 in Q1.16, Horner form with rounding per pass
   function automatic logic [Q16_W-1:0] smoothstep_q16(logic [Q16_W-1:0] t);
      logic [63:0] tt;
      logic [63:0] q;
      logic [63:0] r;
      tt = 64'(t);
      q = 64'd6 * tt * tt + (64'd10 << 32) - 64'd15 * tt * 64'd65536;
      r = (q + 64'h8000) >> 16;
      for (int i = 0; i < POLY_MUL_STEPS; i++)
         r = (r * tt + 64'h8000) >> 16;
      if (r > 64'd65536)
         r = 64'd65536;
      return r[Q16_W-1:0];
   endfunction

   // Move from start toward home by alpha, rounding the step magnitude half up
   function automatic logic [VAL_W-1:0] lerp_toward(logic [VAL_W-1:0] s,
                                                    logic [VAL_W-1:0] h,
                                                    logic [Q16_W-1:0] alpha);
      logic [63:0] a;
      logic [63:0] d;
      logic [63:0] mag;
      a = 64'(alpha);
      if (h >= s) begin
         d = 64'(h - s);
         mag = (a * d + 64'h8000) >> 16;
         return s + mag[VAL_W-1:0];
      end
      d = 64'(s - h);
      mag = (a * d + 64'h8000) >> 16;
      return s - mag[VAL_W-1:0];
   endfunction

   // Apply one accepted transfer to the predictor; returns setpoints queued
   function automatic int advance_ramp(logic [1:0] func, logic [JOINT_W-1:0] joint,
                                       logic [VAL_W-1:0] s, logic [VAL_W-1:0] d);
      logic [Q16_W-1:0] t;
      logic [Q16_W-1:0] alpha;
      logic [Q16_W:0]   next_t;
      logic             done;
      setpoint_type     sp;
      case (func)
         qir_pkg::FUNC_LOAD_START: begin
            if (joint < JOINTS) begin
               start_stiff[joint] = s;
               start_damp[joint] = d;
            end
         end
         qir_pkg::FUNC_LOAD_HOME: begin
            if (joint < JOINTS) begin
               home_stiff[joint] = s;
               home_damp[joint] = d;
            end
         end
         qir_pkg::FUNC_RESTART: begin
            ramp_time = '0;
            ramp_armed = 1'b1;
         end
         default: begin
            if (!ramp_armed)
               return 0;
            t = (ramp_time > ONE_Q16) ? ONE_Q16 : ramp_time;
            alpha = smoothstep_q16(t);
            done = (t >= ONE_Q16);
            for (int j = 0; j < JOINTS; j++) begin
               sp.joint = JOINT_W'(j);
               sp.stiff = lerp_toward(start_stiff[j], home_stiff[j], alpha);
               sp.damp = lerp_toward(start_damp[j], home_damp[j], alpha);
               sp.blend = alpha;
               sp.last = (j == JOINTS - 1);
               sp.fin = done;
               pending_setpoints.push_back(sp);
            end
            if (done) begin
               ramp_armed = 1'b0;
            end else begin
               next_t = {1'b0, t} + {1'b0, tau_now};
               ramp_time = (next_t > {1'b0, ONE_Q16}) ? ONE_Q16 : next_t[Q16_W-1:0];
            end
            return JOINTS;
         end
      endcase
      return 0;
   endfunction

   function automatic stim_row_type load_row(qir_pkg::func_type f, int j,
                                             logic [VAL_W-1:0] s, logic [VAL_W-1:0] d);
      stim_row_type row;
      row = '0;
      row.func = f;
      row.joint = JOINT_W'(j);
      row.stiff = s;
      row.damp = d;
      return row;
   endfunction

   function automatic stim_row_type op_row(qir_pkg::func_type f);
      stim_row_type row;
      row = '0;
      row.func = f;
      row.stiff = VAL_W'($urandom);
      row.damp = VAL_W'($urandom);
      return row;
   endfunction

   function automatic stim_row_type tick_pinned(int j, logic [VAL_W-1:0] s,
                                                logic [VAL_W-1:0] d,
                                                logic [Q16_W-1:0] blend, logic fin);
      stim_row_type row;
      row = '0;
      row.func = qir_pkg::FUNC_TICK;
      row.joint = JOINT_W'(j);
      row.typed = 1'b1;
      row.exp_stiff = s;
      row.exp_damp = d;
      row.exp_blend = blend;
      row.exp_fin = fin;
      return row;
   endfunction

   function automatic stim_row_type tau_row(logic [TAU_W-1:0] v);
      stim_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.tau = v;
      return row;
   endfunction

   // Corner-heavy value for a stored stiffness or damping
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // Mostly ticks so ramps run to completion; some loads outside the joint range
   function automatic stim_row_type random_item();
      stim_row_type row;
      int sel;
      int j;
      sel = $urandom_range(0, 99);
      j = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, JOINTS - 1);
      if (sel < 14)
         row = load_row(qir_pkg::FUNC_LOAD_START, j, pick_value(), pick_value());
      else if (sel < 28)
         row = load_row(qir_pkg::FUNC_LOAD_HOME, j, pick_value(), pick_value());
      else if (sel < 36)
         row = op_row(qir_pkg::FUNC_RESTART);
      else
         row = op_row(qir_pkg::FUNC_TICK);
      if (sel >= 28)
         row.joint = JOINT_W'($urandom_range(0, 63));
      return row;
   endfunction

   function automatic void check_field(logic [JOINT_W-1:0] j, string field,
                                       logic [Q16_W-1:0] want, logic [Q16_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: joint %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, j, field, want, got);
         mismatches++;
      end
   endfunction

   // Present one item, hold it until the transfer, then predict its setpoints
   task automatic send_item(stim_row_type row);
      int made;
      int idx;
      req_valid <= 1'b1;
      req_func <= row.func;
      req_joint <= row.joint;
      req_stiffness <= row.stiff;
      req_damping <= row.damp;
      do @(posedge clock); while (req_stall);
      items_sent++;
      made = advance_ramp(row.func, row.joint, row.stiff, row.damp);
      if (made != 0)
         active_ticks++;
      // pin the setpoint of the named joint to the value read off directly
      if (row.typed && made != 0) begin
         idx = pending_setpoints.size() - JOINTS + row.joint;
         pending_setpoints[idx].stiff = row.exp_stiff;
         pending_setpoints[idx].damp = row.exp_damp;
         pending_setpoints[idx].blend = row.exp_blend;
         pending_setpoints[idx].fin = row.exp_fin;
      end
   endtask

   // Drop valid for a random burst now and then
   task automatic insert_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Hold the sender until every setpoint is out, then let the pipeline empty
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_setpoints.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_tau(logic [TAU_W-1:0] v);
      settle_block();
      csr_valid <= 1'b1;
      csr_tau_step <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tau_now = v;
      tau_writes++;
   endtask

   // Result side: random stall bursts, none while calm
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result transfer with the oldest pending setpoint
   always @(posedge clock) begin : setpoint_monitor
      setpoint_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         setpoints_seen++;
         if (pending_setpoints.size() == 0) begin
            $display("%0t ns: unexpected setpoint, expected none, actual joint %0d",
                     $time, rsp_joint_out);
            mismatches++;
         end else begin
            want = pending_setpoints.pop_front();
            check_field(want.joint, "joint_out", Q16_W'(want.joint), Q16_W'(rsp_joint_out));
            check_field(want.joint, "stiffness_ref", Q16_W'(want.stiff),
                        Q16_W'(rsp_stiffness_ref));
            check_field(want.joint, "damping_ref", Q16_W'(want.damp),
                        Q16_W'(rsp_damping_ref));
            check_field(want.joint, "blend", want.blend, rsp_blend);
            check_field(want.joint, "last", Q16_W'(want.last), Q16_W'(rsp_last));
            check_field(want.joint, "finished", Q16_W'(want.fin), Q16_W'(rsp_finished));
         end
      end
   end

   initial begin : stimulus
      stim_row_type     plan[$];
      logic [TAU_W-1:0] phase_tau [RAND_PHASES];
      int               waited;

      // known input levels and predictor reset state
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = qir_pkg::FUNC_LOAD_START;
      req_joint = '0;
      req_stiffness = '0;
      req_damping = '0;
      csr_valid = 1'b0;
      csr_tau_step = '0;
      calm = 1'b0;
      mismatches = 0;
      items_sent = 0;
      setpoints_seen = 0;
      active_ticks = 0;
      tau_writes = 0;
      for (int j = 0; j < JOINTS; j++) begin
         start_stiff[j] = '0;
         start_damp[j] = '0;
         home_stiff[j] = '0;
         home_damp[j] = '0;
      end
      ramp_time = '0;
      ramp_armed = 1'b0;
      tau_now = TAU_RESET;

      // idle tick, then a ramp over the all-zero tables at t = 0
      plan.push_back(op_row(qir_pkg::FUNC_TICK));
      plan.push_back(op_row(qir_pkg::FUNC_RESTART));
      plan.push_back(tick_pinned(0, 16'h0000, 16'h0000, '0, 1'b0));
      // extremes into the tables; out-of-range joints must be dropped
      plan.push_back(load_row(qir_pkg::FUNC_LOAD_START, 0, 16'hFFFF, 16'hFFFF));
      plan.push_back(load_row(qir_pkg::FUNC_LOAD_HOME, 0, 16'h0000, 16'h0000));
      plan.push_back(load_row(qir_pkg::FUNC_LOAD_START, JOINTS - 1, 16'h0001, 16'h8000));
      plan.push_back(load_row(qir_pkg::FUNC_LOAD_HOME, JOINTS - 1, 16'hFFFF, 16'hFFFF));
      plan.push_back(load_row(qir_pkg::FUNC_LOAD_START, 63, 16'hAAAA, 16'h5555));
      plan.push_back(load_row(qir_pkg::FUNC_LOAD_HOME, JOINTS, 16'h1234, 16'h4321));
      plan.push_back(load_row(qir_pkg::FUNC_LOAD_START, 3, 16'h5555, 16'hAAAA));
      plan.push_back(load_row(qir_pkg::FUNC_LOAD_HOME, 3, 16'hAAAA, 16'h5555));
      plan.push_back(op_row(qir_pkg::FUNC_RESTART));
      plan.push_back(tick_pinned(0, 16'hFFFF, 16'hFFFF, '0, 1'b0));
      plan.push_back(op_row(qir_pkg::FUNC_TICK));
      // full step: t = 0 then t = 1.0 finishes; the next tick is silent
      plan.push_back(tau_row(17'd65536));
      plan.push_back(op_row(qir_pkg::FUNC_RESTART));
      plan.push_back(tick_pinned(JOINTS - 1, 16'h0001, 16'h8000, '0, 1'b0));
      plan.push_back(tick_pinned(0, 16'h0000, 16'h0000, ONE_Q16, 1'b1));
      plan.push_back(op_row(qir_pkg::FUNC_TICK));
      // zero step holds the ramp at t = 0
      plan.push_back(tau_row(17'd0));
      plan.push_back(op_row(qir_pkg::FUNC_RESTART));
      plan.push_back(tick_pinned(3, 16'h5555, 16'hAAAA, '0, 1'b0));
      plan.push_back(tick_pinned(3, 16'h5555, 16'hAAAA, '0, 1'b0));
      // load and restart mid-ramp; t saturates at 1.0 on the third tick
      plan.push_back(tau_row(17'd40000));
      plan.push_back(op_row(qir_pkg::FUNC_RESTART));
      plan.push_back(op_row(qir_pkg::FUNC_TICK));
      plan.push_back(load_row(qir_pkg::FUNC_LOAD_HOME, 5, 16'hFFFF, 16'h0000));
      plan.push_back(op_row(qir_pkg::FUNC_TICK));
      plan.push_back(op_row(qir_pkg::FUNC_RESTART));
      plan.push_back(tick_pinned(JOINTS - 1, 16'h0001, 16'h8000, '0, 1'b0));
      plan.push_back(op_row(qir_pkg::FUNC_TICK));
      plan.push_back(tick_pinned(JOINTS - 1, 16'hFFFF, 16'hFFFF, ONE_Q16, 1'b1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            write_tau(plan[i].tau);
         end else begin
            send_item(plan[i]);
            insert_gap();
         end
      end

      // random phases, each under its own step size; the last runs without idling
      phase_tau[0] = 17'd65536;
      phase_tau[1] = 17'd1;
      phase_tau[2] = TAU_W'($urandom_range(16384, 65535));
      phase_tau[3] = TAU_W'($urandom_range(4096, 16383));
      phase_tau[4] = TAU_W'($urandom_range(1, 65536));
      phase_tau[5] = TAU_W'($urandom_range(8192, 65536));
      for (int p = 0; p < RAND_PHASES; p++) begin
         write_tau(phase_tau[p]);
         calm = (p == RAND_PHASES - 1);
         send_item(op_row(qir_pkg::FUNC_RESTART));
         for (int k = 1; k < PHASE_ITEMS; k++) begin
            if (p == 2 && k == PHASE_ITEMS / 2)
               settle_block();
            send_item(random_item());
            insert_gap();
         end
      end

      // drain, bounded, then allow a late stray result to show up
      req_valid <= 1'b0;
      waited = 0;
      while (pending_setpoints.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      if (pending_setpoints.size() != 0) begin
         $display("%0t ns: %0d setpoints never arrived, expected 0 left, actual %0d",
                  $time, pending_setpoints.size(), pending_setpoints.size());
         mismatches++;
      end

      $display("Sent %0d items, checked %0d setpoints from %0d armed ticks, %0d mismatches.",
               items_sent, setpoints_seen, active_ticks, mismatches);
      $display("Step sizes written %0d times, including 0, 1 and a full step.", tau_writes);
      if (mismatches == 0)
         $display("quintic_impedance_ramp regression: pass");
      else
         $display("quintic_impedance_ramp regression: fail");
      $finish;
   end

   // Hard stop far beyond the slowest legal run
   initial begin : watchdog
      #1_000_000;
      $display("quintic_impedance_ramp regression: fail");
      $finish;
   end

endmodule
